>>> hdl/multilane_lms_tap_updater_core_macros.svh
// Assertion helpers for the LMS tap updater.
`ifndef MULTILANE_LMS_TAP_UPDATER_CORE_MACROS_SVH
`define MULTILANE_LMS_TAP_UPDATER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LMSTU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmstu assertion failed");

// Next-cycle implication, checked outside reset.
`define LMSTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmstu assertion failed");

`endif

>>> hdl/lmstu_pkg.sv
package lmstu_pkg;

  localparam int Q_W         = 32;
  localparam int MU_W        = 24;
  localparam int LANE_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;

  localparam logic [MU_W-1:0] MU_FFE_RESET = 24'd167772;
  localparam logic [MU_W-1:0] MU_DFE_RESET = 24'd0;
  localparam logic signed [Q_W-1:0] Q_ONE  = 32'sh0100_0000;

  // command codes
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_TAP    = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_FINE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RESTORED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MU_FFE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MU_DFE = 1'd1;

  // controls from the sequencer to the update datapath
  typedef struct packed {
    logic step_en;   // load mu * error product
    logic delta_en;  // load step * sample product
    logic feedback;  // decision-feedback tap: subtract
  } dp_ctrl_t;

endpackage

>>> hdl/lmstu_tap_mem.sv
module lmstu_tap_mem
  import lmstu_pkg::*;
#(
  parameter int DEPTH = 150,
  parameter int AW    = 8
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic signed [Q_W-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic signed [Q_W-1:0] wr_data
);

  logic signed [Q_W-1:0] tap_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tap_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tap_mem[rd_addr];
    end
  end

endmodule

>>> hdl/lmstu_update.sv
module lmstu_update
  import lmstu_pkg::*;
(
  input  logic                  clk,
  input  dp_ctrl_t              ctrl,
  input  logic [MU_W-1:0]       mu,
  input  logic signed [Q_W-1:0] held_error,
  input  logic signed [Q_W-1:0] sample,
  input  logic signed [Q_W-1:0] tap_old,
  output logic signed [Q_W-1:0] tap_new
);

  localparam logic signed [56:0] HALF1 = 57'sd8388608;
  localparam logic signed [63:0] HALF2 = 64'sd8388608;

  logic signed [56:0] prod1;
  logic signed [56:0] rnd1;
  logic signed [31:0] step;
  logic signed [63:0] prod2;
  logic signed [63:0] rnd2;
  logic signed [39:0] delta;
  logic signed [40:0] tap_ext;
  logic signed [40:0] delta_ext;
  logic signed [40:0] sum;

  // Q0.24 * Q8.24, rounded back to Q8.24; always fits 32 bits
  always_ff @(posedge clk) begin
    if (ctrl.step_en) begin
      prod1 <= $signed({1'b0, mu}) * held_error;
    end
  end

  assign rnd1 = prod1 + HALF1;
  assign step = rnd1[55:24];

  always_ff @(posedge clk) begin
    if (ctrl.delta_en) begin
      prod2 <= step * sample;
    end
  end

  assign rnd2      = prod2 + HALF2;
  assign delta     = rnd2[63:24];
  assign tap_ext   = {{9{tap_old[Q_W-1]}}, tap_old};
  assign delta_ext = {delta[39], delta};

  always_comb begin
    if (ctrl.feedback) begin
      sum = tap_ext - delta_ext;
    end else begin
      sum = tap_ext + delta_ext;
    end
    if (!sum[40] && (|sum[39:31])) begin
      tap_new = 32'sh7FFF_FFFF;
    end else if (sum[40] && !(&sum[39:31])) begin
      tap_new = 32'sh8000_0000;
    end else begin
      tap_new = sum[31:0];
    end
  end

endmodule

>>> hdl/multilane_lms_tap_updater_core.sv
// LMS tap updater for several equalizer lanes, served round robin.
// Input channel (in_valid/in_ready): command 0 is a header carrying the
// error and a reset request; command 1 is one sample or decision history
// for the next tap of the current lane. Every item yields one result on
// the output channel (out_valid/out_ready): a header response, or the
// updated tap with last set on the final tap of the lane's packet.
// Headers and samples outside a packet go from accept to the result state;
// a tap update goes through accept, tap memory read plus mu*error multiply,
// step*sample multiply, saturating add and write back. One item is in
// work at a time, as the tap memory read-modify-write requires.
// A result sits in the output register until taken; the next item is
// accepted meanwhile, and only its own result waits on a stalled receiver.
// Reset returns every lane to one at the cursor tap and zero elsewhere at
// once (a per-lane fill count masks the memory), lane 0 holds the token,
// and mu_ffe/mu_dfe return to their defaults. cfg_we writes a register
// in the same cycle; write only while the block is idle.
module multilane_lms_tap_updater_core
  import lmstu_pkg::*;
#(
  parameter int LANES         = 10,
  parameter int PRE_TAPS      = 3,
  parameter int POST_TAPS     = 10,
  parameter int FEEDBACK_TAPS = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic                   reset_request,
  input  logic signed [Q_W-1:0]  value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   kind,
  output logic [LANE_W-1:0]      lane,
  output logic [STATUS_W-1:0]    status,
  output logic signed [Q_W-1:0]  tap_value,
  output logic                   last,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [MU_W-1:0]        cfg_data
);

  `include "multilane_lms_tap_updater_core_macros.svh"

  localparam int NFFE  = PRE_TAPS + 1 + POST_TAPS;
  localparam int NTAPS = NFFE + FEEDBACK_TAPS;
  localparam int DEPTH = LANES * NTAPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (NTAPS > 1) ? $clog2(NTAPS) : 1;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int FW    = $clog2(NTAPS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0]            state;
  logic [LW-1:0]         lane_token;
  logic [PW-1:0]         tap_position;
  logic signed [Q_W-1:0] held_error;
  logic                  in_packet;
  logic                  reset_pending;
  logic [FW-1:0]         fill [LANES];
  logic [MU_W-1:0]       mu_ffe;
  logic [MU_W-1:0]       mu_dfe;
  logic signed [Q_W-1:0] cur_sample;
  logic [AW-1:0]         tap_addr;
  logic                  feedback;
  logic                  res_kind;
  logic [STATUS_W-1:0]   res_status;

  logic                  in_take;
  logic                  out_free;
  logic                  tap_done;
  logic                  res_load;
  logic                  pos_last;
  logic [FW-1:0]         fill_cur;
  logic                  tap_written;
  logic signed [Q_W-1:0] rd_data;
  logic signed [Q_W-1:0] tap_old;
  logic signed [Q_W-1:0] tap_new;
  dp_ctrl_t              dp_ctrl;

  assign in_ready    = (state == ST_IDLE);
  assign in_take     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign tap_done    = (state == ST_ADD) && out_free;
  assign res_load    = tap_done || ((state == ST_RES) && out_free);
  assign pos_last    = (tap_position == PW'(NTAPS - 1));
  assign fill_cur    = fill[lane_token];
  assign tap_written = (FW'(tap_position) < fill_cur);

  // taps past the fill count still hold their initial value
  always_comb begin
    if (tap_written) begin
      tap_old = rd_data;
    end else if (tap_position == PW'(PRE_TAPS)) begin
      tap_old = Q_ONE;
    end else begin
      tap_old = '0;
    end
  end

  assign dp_ctrl.step_en  = (state == ST_READ);
  assign dp_ctrl.delta_en = (state == ST_MUL);
  assign dp_ctrl.feedback = feedback;

  lmstu_tap_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_tap_mem (
    .clk    (clk),
    .rd_en  (state == ST_READ),
    .rd_addr(tap_addr),
    .rd_data(rd_data),
    .wr_en  (tap_done),
    .wr_addr(tap_addr),
    .wr_data(tap_new)
  );

  lmstu_update u_update (
    .clk       (clk),
    .ctrl      (dp_ctrl),
    .mu        (feedback ? mu_dfe : mu_ffe),
    .held_error(held_error),
    .sample    (cur_sample),
    .tap_old   (tap_old),
    .tap_new   (tap_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_ffe <= MU_FFE_RESET;
      mu_dfe <= MU_DFE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MU_FFE: mu_ffe <= cfg_data;
        REG_MU_DFE: mu_dfe <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      lane_token    <= '0;
      tap_position  <= '0;
      held_error    <= '0;
      in_packet     <= 1'b0;
      reset_pending <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (command == CMD_HEADER) begin
              held_error    <= value;
              reset_pending <= reset_request;
              tap_position  <= '0;
              in_packet     <= 1'b1;
              if (reset_request) begin
                fill[lane_token] <= '0;
              end
              res_kind   <= KIND_HEADER;
              res_status <= reset_request ? STATUS_RESTORED : STATUS_FINE;
              state      <= ST_RES;
            end else if (!in_packet) begin
              res_kind   <= KIND_TAP;
              res_status <= STATUS_OUTSIDE;
              state      <= ST_RES;
            end else begin
              cur_sample <= value;
              tap_addr   <= AW'(int'(lane_token) * NTAPS + int'(tap_position));
              feedback   <= ({{(32-PW){1'b0}}, tap_position} >= 32'(NFFE));
              state      <= ST_READ;
            end
          end
        end
        ST_READ: state <= ST_MUL;
        ST_MUL:  state <= ST_ADD;
        ST_ADD: begin
          if (out_free) begin
            kind      <= KIND_TAP;
            lane      <= LANE_W'(lane_token);
            status    <= reset_pending ? STATUS_RESTORED : STATUS_FINE;
            tap_value <= tap_new;
            last      <= pos_last;
            if (!tap_written) begin
              fill[lane_token] <= fill_cur + FW'(1);
            end
            if (pos_last) begin
              in_packet    <= 1'b0;
              tap_position <= '0;
              lane_token   <= (lane_token == LW'(LANES - 1)) ? '0 : lane_token + LW'(1);
            end else begin
              tap_position <= tap_position + PW'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_RES: begin
          if (out_free) begin
            kind      <= res_kind;
            lane      <= LANE_W'(lane_token);
            status    <= res_status;
            tap_value <= '0;
            last      <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LMSTU_ASSERT_NEXT(a_one_item_in_work, clk, rst, in_take, !in_ready)
  `LMSTU_ASSERT_IMPL(a_fill_bounded, clk, rst, 1'b1, fill_cur <= FW'(NTAPS))
  `LMSTU_ASSERT_IMPL(a_outside_is_empty, clk, rst,
                     out_valid && (status == STATUS_OUTSIDE), (tap_value == '0) && !last)

endmodule
